@@ rtl/glj_pkg.sv @@
// Shared types and constants of the greedy line justifier.
package glj_pkg;

	// Width of the line width register and of every line length or gap.
	localparam int LEN_W = 7;

	// Reset value and upper limit of the line width register.
	localparam logic [LEN_W-1:0] WIDTH_RESET = 7'd80;
	localparam logic [LEN_W-1:0] WIDTH_MAX = 7'd120;

	// Depth of the command queue between front and back.
	localparam int FIFO_DEPTH = 4;

	// Commands that the front hands to the back.
	typedef enum logic [1:0] {
		OP_STORE,
		OP_FLUSH,
		OP_FINAL,
		OP_LONG
	} cmd_op_t;

	// Control part of one command; the word and the count travel beside it.
	typedef struct packed {
		cmd_op_t op;
		logic last;
		logic eot;
		logic [LEN_W-1:0] len;
	} cmd_ctl_t;

	// States of the back end.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_PRIME,
		BK_EMIT
	} bk_state_t;

endpackage

@@ rtl/glj_ifs.sv @@
// Channel interfaces of the greedy line justifier: words in, placed words out, configuration.
interface glj_in_if #(parameter int WORD_BITS = 7) ();
	logic valid;
	logic ready;
	logic [WORD_BITS-1:0] word_length;
	logic end_of_text;

	modport source (output valid, output word_length, output end_of_text, input ready);
	modport sink (input valid, input word_length, input end_of_text, output ready);
endinterface

interface glj_out_if import glj_pkg::*; #(parameter int WORD_BITS = 7) ();
	logic valid;
	logic ready;
	logic [WORD_BITS-1:0] out_word_length;
	logic [LEN_W-1:0] gap_after;
	logic line_end;
	logic final_line;
	logic too_long;
	logic last;

	modport source (output valid, output out_word_length, output gap_after, output line_end,
		output final_line, output too_long, output last, input ready);
	modport sink (input valid, input out_word_length, input gap_after, input line_end,
		input final_line, input too_long, input last, output ready);
endinterface

interface glj_cfg_if import glj_pkg::*; ();
	logic valid;
	logic ready;
	logic [LEN_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/glj_fifo.sv @@
// Small command queue between the front and the back of the line justifier.
module glj_fifo #(
	parameter int DATA_W = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [DATA_W-1:0] din,
	output logic full,
	input logic pop,
	output logic [DATA_W-1:0] dout,
	output logic empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic do_push;
	logic do_pop;

	assign full = (fill_q == CNT_W'(DEPTH));
	assign empty = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/glj_front.sv @@
// Front end: takes words, tracks the open line and issues commands to the back end.
module glj_front import glj_pkg::*; #(
	parameter int MAX_WORDS = 64,
	parameter int WORD_BITS = 7
) (
	input logic clk,
	input logic arst_n,
	input logic [LEN_W-1:0] line_width,
	glj_in_if.sink words,
	input logic cmd_full,
	output logic cmd_push,
	output cmd_ctl_t cmd_ctl,
	output logic [WORD_BITS-1:0] cmd_word,
	output logic [$clog2(MAX_WORDS+1)-1:0] cmd_cnt
);
	localparam int CNT_W = $clog2(MAX_WORDS + 1);
	localparam int SUM_W = ((WORD_BITS > LEN_W) ? WORD_BITS : LEN_W) + 2;

	logic [CNT_W-1:0] cnt_q;
	logic [LEN_W-1:0] len_q;
	logic pend_j_q, pend_a_q, pend_f_q;
	logic last_j_q, last_a_q, last_f_q;
	logic long_q, eot_q;
	logic [WORD_BITS-1:0] word_q;

	logic busy, accept;
	logic w_zero, over, no_fit, buf_full, any;
	logic c_j, c_f;
	logic [SUM_W-1:0] w_ext, wid_ext, fit_sum, new_len;

	assign busy = pend_j_q || pend_a_q || pend_f_q;
	assign words.ready = !busy;
	assign accept = words.valid && !busy;

	// Classify the arriving word against the open line.
	always_comb begin
		w_ext = SUM_W'(words.word_length);
		wid_ext = SUM_W'(line_width);
		fit_sum = SUM_W'(len_q) + SUM_W'(1) + w_ext;
		w_zero = (words.word_length == '0);
		over = (w_ext > wid_ext);
		no_fit = (fit_sum > wid_ext);
		buf_full = (cnt_q == CNT_W'(MAX_WORDS));
		any = (cnt_q != '0);
		c_j = !w_zero && any && (over || buf_full || no_fit);
		c_f = words.end_of_text && (w_zero ? any : !over);
	end

	// The oldest pending command goes out first.
	always_comb begin
		cmd_push = busy && !cmd_full;
		cmd_word = word_q;
		cmd_cnt = cnt_q;
		cmd_ctl.len = len_q;
		cmd_ctl.eot = eot_q;
		if (pend_j_q) begin
			cmd_ctl.op = OP_FLUSH;
			cmd_ctl.last = last_j_q;
		end else if (pend_a_q) begin
			cmd_ctl.op = long_q ? OP_LONG : OP_STORE;
			cmd_ctl.last = last_a_q;
		end else begin
			cmd_ctl.op = OP_FINAL;
			cmd_ctl.last = last_f_q;
		end
		new_len = SUM_W'(len_q) + SUM_W'(word_q) + SUM_W'(cnt_q != '0);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= words.word_length;
			eot_q <= words.end_of_text;
			long_q <= over;
			last_f_q <= c_f;
			last_a_q <= over;
			last_j_q <= c_j && !c_f && !over;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_j_q <= 1'b0;
			pend_a_q <= 1'b0;
			pend_f_q <= 1'b0;
			cnt_q <= '0;
			len_q <= '0;
		end else if (accept) begin
			pend_j_q <= c_j;
			pend_a_q <= !w_zero;
			pend_f_q <= c_f;
		end else if (cmd_push) begin
			if (pend_j_q) begin
				pend_j_q <= 1'b0;
				cnt_q <= '0;
				len_q <= '0;
			end else if (pend_a_q) begin
				pend_a_q <= 1'b0;
				if (!long_q) begin
					cnt_q <= cnt_q + 1'b1;
					len_q <= new_len[LEN_W-1:0];
				end
			end else begin
				pend_f_q <= 1'b0;
				cnt_q <= '0;
				len_q <= '0;
			end
		end
	end

endmodule

@@ rtl/glj_back.sv @@
// Back end: buffers words, justifies closed lines and emits one placed word per transaction.
module glj_back import glj_pkg::*; #(
	parameter int MAX_WORDS = 64,
	parameter int WORD_BITS = 7
) (
	input logic clk,
	input logic arst_n,
	input logic [LEN_W-1:0] line_width,
	input logic cmd_valid,
	input cmd_ctl_t cmd_ctl,
	input logic [WORD_BITS-1:0] cmd_word,
	input logic [$clog2(MAX_WORDS+1)-1:0] cmd_cnt,
	output logic cmd_pop,
	glj_out_if.source results
);
	localparam int CNT_W = $clog2(MAX_WORDS + 1);
	localparam int IDX_W = $clog2(MAX_WORDS);
	localparam int REM_W = CNT_W + 1;
	localparam int STEP_W = $clog2(LEN_W);

	logic [WORD_BITS-1:0] mem [MAX_WORDS];
	logic [WORD_BITS-1:0] mem_rd_q;

	bk_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, div_q;
	logic [IDX_W-1:0] idx_q, rd_addr;
	logic [LEN_W-1:0] each_q, dvd_q;
	logic [REM_W-1:0] rem_q, rem_sh;
	logic [STEP_W-1:0] step_q;
	logic fin_q, last_q;

	logic out_valid_q;
	logic [WORD_BITS-1:0] out_word_q;
	logic [LEN_W-1:0] out_gap_q;
	logic out_lend_q, out_fin_q, out_long_q, out_last_q;

	logic slot_free, div_ge, div_done, at_last, emit, load_long;
	logic [LEN_W-1:0] slack, gap;

	assign results.valid = out_valid_q;
	assign results.out_word_length = out_word_q;
	assign results.gap_after = out_gap_q;
	assign results.line_end = out_lend_q;
	assign results.final_line = out_fin_q;
	assign results.too_long = out_long_q;
	assign results.last = out_last_q;

	// Datapath terms for the control and register blocks.
	always_comb begin
		slot_free = !out_valid_q || results.ready;
		slack = (line_width > cmd_ctl.len) ? line_width - cmd_ctl.len : '0;
		rem_sh = {rem_q[CNT_W-1:0], dvd_q[LEN_W-1]};
		div_ge = (rem_sh >= REM_W'(div_q));
		div_done = (step_q == STEP_W'(LEN_W - 1));
		at_last = (CNT_W'(idx_q) == cnt_q - 1'b1);
		if (at_last) begin
			gap = '0;
		end else if (fin_q) begin
			gap = LEN_W'(1);
		end else begin
			gap = LEN_W'(1) + each_q + LEN_W'(REM_W'(idx_q) < rem_q);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					if (cmd_ctl.op == OP_FLUSH) begin
						state_d = (cmd_cnt > CNT_W'(1)) ? BK_DIV : BK_PRIME;
					end else if (cmd_ctl.op == OP_FINAL) begin
						state_d = BK_PRIME;
					end
				end
			end
			BK_DIV: begin
				if (div_done) begin
					state_d = BK_PRIME;
				end
			end
			BK_PRIME: begin
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (slot_free && at_last) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Control outputs.
	always_comb begin
		cmd_pop = 1'b0;
		emit = 1'b0;
		load_long = 1'b0;
		rd_addr = idx_q;
		case (state_q)
			BK_IDLE: begin
				cmd_pop = cmd_valid && (cmd_ctl.op != OP_LONG || slot_free);
				load_long = cmd_valid && cmd_ctl.op == OP_LONG && slot_free;
			end
			BK_EMIT: begin
				emit = slot_free;
				if (slot_free && !at_last) begin
					rd_addr = idx_q + 1'b1;
				end
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	// Word store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && cmd_valid && cmd_ctl.op == OP_STORE) begin
			mem[cmd_cnt[IDX_W-1:0]] <= cmd_word;
		end
		mem_rd_q <= mem[rd_addr];
	end

	// Line and divider registers.
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				cnt_q <= cmd_cnt;
				div_q <= cmd_cnt - 1'b1;
				dvd_q <= slack;
				fin_q <= (cmd_ctl.op == OP_FINAL);
				last_q <= cmd_ctl.last;
				each_q <= '0;
				rem_q <= '0;
				step_q <= '0;
				idx_q <= '0;
			end
			BK_DIV: begin
				rem_q <= div_ge ? rem_sh - REM_W'(div_q) : rem_sh;
				each_q <= {each_q[LEN_W-2:0], div_ge};
				dvd_q <= {dvd_q[LEN_W-2:0], 1'b0};
				step_q <= step_q + 1'b1;
			end
			BK_EMIT: begin
				if (emit && !at_last) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			default: begin
				idx_q <= '0;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (load_long) begin
			out_word_q <= cmd_word;
			out_gap_q <= '0;
			out_lend_q <= 1'b1;
			out_fin_q <= cmd_ctl.eot;
			out_long_q <= 1'b1;
			out_last_q <= cmd_ctl.last;
		end else if (emit) begin
			out_word_q <= mem_rd_q;
			out_gap_q <= gap;
			out_lend_q <= at_last;
			out_fin_q <= fin_q;
			out_long_q <= 1'b0;
			out_last_q <= last_q && at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_long || emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/greedy_line_justifier_unit.sv @@
// Top level of the greedy line justifier: configuration register, front, command queue, back.
//
// The block takes word lengths one transaction at a time and packs them greedily into lines of
// at most line_width characters, with one space between neighbors. When a word does not fit,
// the open line is closed: every word of it comes out as one transaction on the results
// channel, in order, with the spaces to print after it; the slack is spread evenly and the
// leftmost gaps take one extra space. A word with end_of_text closes its line as the last line,
// with single spaces. A word wider than line_width is emitted alone with too_long set. The last
// transaction that an input word causes carries last. A word that only joins the open line, or
// an overlong word with nothing buffered, is accepted and its command then goes into a four-entry
// queue. A word that also closes the open line passes a flush command before its own, and one
// that closes a line and ends the text as its last line passes a final command after it. No new
// word is taken until the commands of the last one are queued; a full queue holds them until
// the back frees an entry. The front keeps taking words while the back drains earlier lines.
// The back pops a stored word into the word store and an overlong word into the output
// register. A justified line of two or more words runs through the bit-serial divider that
// splits the slack, a first read of the word store and the output, one word per cycle while the
// output register is free. A final line or a one-word line skips the divider. Configuration is
// accepted in any cycle; values above 120 are stored as 120, and the reset value is 80.
module greedy_line_justifier_unit import glj_pkg::*; #(
	parameter int MAX_WORDS = 64,
	parameter int WORD_BITS = 7
) (
	input logic clk,
	input logic arst_n,
	glj_cfg_if.sink cfg,
	glj_in_if.sink words,
	glj_out_if.source results
);
	localparam int CNT_W = $clog2(MAX_WORDS + 1);
	localparam int CMD_W = $bits(cmd_ctl_t) + WORD_BITS + CNT_W;

	// Line width register; the write port never stalls.
	logic [LEN_W-1:0] line_width_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= WIDTH_RESET;
		end else if (cfg.valid) begin
			line_width_q <= (cfg.data > WIDTH_MAX) ? WIDTH_MAX : cfg.data;
		end
	end

	// Commands from the front, queued for the back.
	logic f_push, q_full, q_empty, b_pop;
	cmd_ctl_t f_ctl, b_ctl;
	logic [WORD_BITS-1:0] f_word, b_word;
	logic [CNT_W-1:0] f_cnt, b_cnt;
	logic [CMD_W-1:0] q_dout;

	glj_front #(
		.MAX_WORDS(MAX_WORDS),
		.WORD_BITS(WORD_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.line_width(line_width_q),
		.words(words),
		.cmd_full(q_full),
		.cmd_push(f_push),
		.cmd_ctl(f_ctl),
		.cmd_word(f_word),
		.cmd_cnt(f_cnt)
	);

	glj_fifo #(
		.DATA_W(CMD_W),
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_push),
		.din({f_ctl, f_word, f_cnt}),
		.full(q_full),
		.pop(b_pop),
		.dout(q_dout),
		.empty(q_empty)
	);

	assign {b_ctl, b_word, b_cnt} = q_dout;

	glj_back #(
		.MAX_WORDS(MAX_WORDS),
		.WORD_BITS(WORD_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.line_width(line_width_q),
		.cmd_valid(!q_empty),
		.cmd_ctl(b_ctl),
		.cmd_word(b_word),
		.cmd_cnt(b_cnt),
		.cmd_pop(b_pop),
		.results(results)
	);

endmodule
